// File: rtl/prle_pkg.sv
`default_nettype none
package prle_pkg;

  localparam int IMAGE_WIDTH  = 320;
  localparam int IMAGE_HEIGHT = 200;
  localparam int PLANE_COUNT  = 4;

  localparam int STORE_DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PIX_W       = 4;
  localparam int IDX_W       = 16;
  localparam int PLANE_W     = ($clog2(PLANE_COUNT) > 2) ? $clog2(PLANE_COUNT) : 2;

  localparam logic [15:0] PLANE_LENGTH_RESET = 16'd64000;

  typedef enum logic [1:0] {
    PHASE_CMD,
    PHASE_LITERAL,
    PHASE_REPEAT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take_item;
    logic load_command;
    logic start_literal;
    logic start_repeat;
    logic rd_item;
    logic pix_rd;
    logic pix_step;
    logic load_out;
  } prle_cmd_t;

  typedef struct packed {
    logic   item_is_read;
    logic   done;
    phase_t phase;
    logic   last_pixel;
    logic   out_free;
  } prle_status_t;

endpackage
`default_nettype wire

// File: rtl/prle_ctrl.sv
`default_nettype none
module prle_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  prle_pkg::prle_status_t status,
  output prle_pkg::prle_cmd_t   cmd
);
  import prle_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.item_is_read) begin
          // Read data lands in the datapath register for the finish state.
          cmd.rd_item = 1'b1;
          state_nxt   = ST_FINISH;
        end else if (status.done) begin
          state_nxt = ST_FINISH;
        end else begin
          case (status.phase)
            PHASE_LITERAL: begin
              cmd.start_literal = 1'b1;
              state_nxt         = ST_PIX_RD;
            end
            PHASE_REPEAT: begin
              cmd.start_repeat = 1'b1;
              state_nxt        = ST_PIX_RD;
            end
            default: begin
              cmd.load_command = 1'b1;
              state_nxt        = ST_FINISH;
            end
          endcase
        end
      end
      ST_PIX_RD: begin
        // The last plane may finish in the middle of a byte or a run.
        if (status.done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.pix_rd = 1'b1;
          state_nxt  = ST_PIX_WR;
        end
      end
      ST_PIX_WR: begin
        cmd.pix_step = 1'b1;
        state_nxt    = status.last_pixel ? ST_FINISH : ST_PIX_RD;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/prle_datapath.sv
`default_nettype none
module prle_datapath (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire  [15:0]            cfg_wr_data,
  input  wire                    in_cmd,
  input  wire  [7:0]             in_stream_byte,
  input  wire  [15:0]            in_read_index,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [3:0]             out_pixel_value,
  output logic                   out_decode_done,
  output logic [1:0]             out_current_plane,
  input  prle_pkg::prle_cmd_t    cmd,
  output prle_pkg::prle_status_t status
);
  import prle_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  logic [15:0]        plane_length_r;
  phase_t             phase_r, phase_nxt;
  logic [7:0]         literal_remaining_r, literal_remaining_nxt;
  logic [7:0]         repeat_count_r, repeat_count_nxt;
  logic [IDX_W-1:0]   pixel_counter_r, pixel_counter_nxt;
  logic [PLANE_W-1:0] plane_index_r, plane_index_nxt;
  logic               done_r, done_nxt;
  logic [7:0]         reps_r, reps_nxt;
  logic [2:0]         bit_cnt_r, bit_cnt_nxt;
  logic               out_valid_r;

  // Item register and result register hold payload only.
  logic               cmd_r;
  logic [7:0]         byte_r;
  logic [IDX_W-1:0]   ridx_r;
  logic [PIX_W-1:0]   out_pixel_r;
  logic               out_done_r;
  logic [1:0]         out_plane_r;

  logic [31:0]        ridx_ext, pix_ext;
  logic               ridx_in_range, pix_in_range;
  logic               pix_on, plane_first, plane_last, wrap;
  logic [IDX_W:0]     cnt_inc;
  logic [PIX_W-1:0]   plane_mask, wr_data;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;

  assign ridx_ext      = 32'(ridx_r);
  assign pix_ext       = 32'(pixel_counter_r);
  assign ridx_in_range = ridx_ext < 32'(STORE_DEPTH);
  assign pix_in_range  = pix_ext < 32'(STORE_DEPTH);

  assign pix_on      = byte_r[3'd7 - bit_cnt_r];
  assign plane_first = plane_index_r == '0;
  assign plane_last  = 32'(plane_index_r) + 32'd1 >= 32'(PLANE_COUNT);
  assign cnt_inc     = {1'b0, pixel_counter_r} + {{IDX_W{1'b0}}, 1'b1};
  assign wrap        = cnt_inc >= {1'b0, plane_length_r};

  // Planes past the pixel width contribute no bit.
  assign plane_mask = (32'(plane_index_r) < 32'(PIX_W)) ?
                      (PIX_W'(1) << plane_index_r) : '0;
  assign wr_data    = plane_first ? {{(PIX_W-1){1'b0}}, pix_on} : (rd_data_r | plane_mask);
  assign mem_we     = cmd.pix_step && pix_in_range && (plane_first || pix_on);
  assign wr_addr    = pix_ext[ADDR_W-1:0];
  assign rd_addr    = cmd.rd_item ? ridx_ext[ADDR_W-1:0] : pix_ext[ADDR_W-1:0];
  assign mem_re     = (cmd.rd_item && ridx_in_range) || (cmd.pix_rd && pix_in_range);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    phase_nxt             = phase_r;
    literal_remaining_nxt = literal_remaining_r;
    repeat_count_nxt      = repeat_count_r;
    pixel_counter_nxt     = pixel_counter_r;
    plane_index_nxt       = plane_index_r;
    done_nxt              = done_r;
    reps_nxt              = reps_r;
    bit_cnt_nxt           = bit_cnt_r;

    if (cmd.load_command) begin
      if (byte_r[7]) begin
        literal_remaining_nxt = {1'b0, byte_r[6:0]} + 8'd1;
        phase_nxt             = PHASE_LITERAL;
      end else begin
        repeat_count_nxt = byte_r + 8'd3;
        phase_nxt        = PHASE_REPEAT;
      end
    end

    if (cmd.start_literal) begin
      reps_nxt              = 8'd1;
      bit_cnt_nxt           = '0;
      literal_remaining_nxt = literal_remaining_r - 8'd1;
      if (literal_remaining_r == 8'd1) begin
        phase_nxt = PHASE_CMD;
      end
    end

    if (cmd.start_repeat) begin
      reps_nxt         = repeat_count_r;
      bit_cnt_nxt      = '0;
      repeat_count_nxt = '0;
      phase_nxt        = PHASE_CMD;
    end

    if (cmd.pix_step) begin
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      if (bit_cnt_r == 3'd7) begin
        reps_nxt = reps_r - 8'd1;
      end
      if (wrap) begin
        pixel_counter_nxt = '0;
        if (plane_last) begin
          done_nxt = 1'b1;
        end else begin
          plane_index_nxt = plane_index_r + PLANE_W'(1);
        end
      end else begin
        pixel_counter_nxt = cnt_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_length_r      <= PLANE_LENGTH_RESET;
      phase_r             <= PHASE_CMD;
      literal_remaining_r <= '0;
      repeat_count_r      <= '0;
      pixel_counter_r     <= '0;
      plane_index_r       <= '0;
      done_r              <= 1'b0;
      reps_r              <= '0;
      bit_cnt_r           <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        plane_length_r <= cfg_wr_data;
      end
      phase_r             <= phase_nxt;
      literal_remaining_r <= literal_remaining_nxt;
      repeat_count_r      <= repeat_count_nxt;
      pixel_counter_r     <= pixel_counter_nxt;
      plane_index_r       <= plane_index_nxt;
      done_r              <= done_nxt;
      reps_r              <= reps_nxt;
      bit_cnt_r           <= bit_cnt_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      cmd_r  <= in_cmd;
      byte_r <= in_stream_byte;
      ridx_r <= in_read_index;
    end
    if (cmd.load_out) begin
      out_pixel_r <= (cmd_r && ridx_in_range) ? rd_data_r : '0;
      out_done_r  <= done_r;
      out_plane_r <= plane_index_r[1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_value   = out_pixel_r;
  assign out_decode_done   = out_done_r;
  assign out_current_plane = out_plane_r;

  assign status.item_is_read = cmd_r;
  assign status.done         = done_r;
  assign status.phase        = phase_r;
  assign status.last_pixel   = (bit_cnt_r == 3'd7) && (reps_r == 8'd1);
  assign status.out_free     = !out_valid_r || out_ready;

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done flag cleared without reset");

  a_plane_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> plane_index_r >= $past(plane_index_r))
    else $error("plane index went backward");

  a_no_step_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_step |-> !done_r)
    else $error("pixel decoded after the last plane");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: rtl/planar_rle_image_decoder_top.sv
`default_nettype none
// Planar run-length image decoder. Each input beat is either a compressed stream byte
// (in_cmd = 0) or a read of one stored 4-bit pixel (in_cmd = 1), and every beat yields
// exactly one result beat carrying the pixel (zero for stream bytes), the done flag and
// the plane being filled. A pixel read or a command byte passes the dispatch and
// finish states before the next beat is accepted. A data byte also decodes its eight
// pixels, once for a literal and count times for a repeat, each a read-modify-write
// of the single pixel store, whose registered read precedes the write. A pending
// result waits in the output register while the next beat is accepted. The store is not
// cleared at reset; pixels must be written by the first plane before they are read.
// plane_length may be written only while the block is idle.
module planar_rle_image_decoder_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_wr_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_cmd,
  input  wire  [7:0]  in_stream_byte,
  input  wire  [15:0] in_read_index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [3:0]  out_pixel_value,
  output logic        out_decode_done,
  output logic [1:0]  out_current_plane
);
  import prle_pkg::*;

  prle_cmd_t    cmd;
  prle_status_t status;

  prle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  prle_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_cmd            (in_cmd),
    .in_stream_byte    (in_stream_byte),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_value   (out_pixel_value),
    .out_decode_done   (out_decode_done),
    .out_current_plane (out_current_plane),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
`default_nettype wire

// File: dv/planar_rle_image_decoder_top_test.sv
`timescale 1ns / 1ps
module planar_rle_image_decoder_top_test;
  import prle_pkg::*;

  localparam logic CMD_STREAM = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct {
    logic        cmd;
    logic [7:0]  sbyte;
    logic [15:0] ridx;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] pixel;
    logic       done;
    logic [1:0] plane;
  } decoder_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid = 1'b0;
  wire         in_ready;
  logic        in_cmd = 1'b0;
  logic [7:0]  in_stream_byte = 8'd0;
  logic [15:0] in_read_index = 16'd0;
  wire         out_valid;
  logic        out_ready = 1'b0;
  wire  [3:0]  out_pixel_value;
  wire         out_decode_done;
  wire  [1:0]  out_current_plane;

  planar_rle_image_decoder_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_stream_byte    (in_stream_byte),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_value   (out_pixel_value),
    .out_decode_done   (out_decode_done),
    .out_current_plane (out_current_plane)
  );

  always #1 clk = ~clk;

  // Shadow copy of the decoder state.
  logic [3:0]  img_store [STORE_DEPTH];
  phase_t      px_phase = PHASE_CMD;
  logic [7:0]  px_lit_left = 8'd0;
  logic [7:0]  px_rep_count = 8'd0;
  logic [15:0] px_count = 16'd0;
  logic [15:0] px_plane_len = PLANE_LENGTH_RESET;
  logic [1:0]  px_plane = 2'd0;
  logic        px_done = 1'b0;
  // Pixels below this index have been written by the first plane.
  int          written_hi = 0;

  in_beat_t       beats_to_send[$];
  decoder_reply_t replies_due[$];
  int             mismatches = 0;

  task automatic expand_byte(input logic [7:0] b);
    int   i;
    int   idx;
    logic on;
    for (i = 0; i < 8; i++) begin
      if (!px_done) begin
        on  = b[7-i];
        idx = int'(px_count);
        if (idx < STORE_DEPTH) begin
          if (px_plane == 2'd0) begin
            img_store[idx] = {3'b000, on};
            if (idx + 1 > written_hi) written_hi = idx + 1;
          end else if (on) begin
            img_store[idx] = img_store[idx] | (4'b0001 << px_plane);
          end
        end
        px_count = px_count + 16'd1;
        if (px_count >= px_plane_len) begin
          px_count = 16'd0;
          if (int'(px_plane) + 1 >= PLANE_COUNT) px_done = 1'b1;
          else px_plane = px_plane + 2'd1;
        end
      end
    end
  endtask

  task automatic decode_beat(input in_beat_t bt);
    decoder_reply_t r;
    int             n;
    r.pixel = 4'd0;
    if (bt.cmd == CMD_READ) begin
      if (int'(bt.ridx) < STORE_DEPTH) r.pixel = img_store[bt.ridx];
    end else if (!px_done) begin
      case (px_phase)
        PHASE_LITERAL: begin
          expand_byte(bt.sbyte);
          px_lit_left = px_lit_left - 8'd1;
          if (px_lit_left == 8'd0) px_phase = PHASE_CMD;
        end
        PHASE_REPEAT: begin
          for (n = 0; n < int'(px_rep_count); n++) expand_byte(bt.sbyte);
          px_rep_count = 8'd0;
          px_phase = PHASE_CMD;
        end
        default: begin
          if (bt.sbyte[7]) begin
            px_lit_left = {1'b0, bt.sbyte[6:0]} + 8'd1;
            px_phase = PHASE_LITERAL;
          end else begin
            px_rep_count = bt.sbyte + 8'd3;
            px_phase = PHASE_REPEAT;
          end
        end
      endcase
    end
    r.done  = px_done;
    r.plane = px_plane;
    replies_due.push_back(r);
  endtask

  task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch on %s at %0t: want %0d got %0d", what, $realtime, want, got);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Never points at a pixel the first plane has not reached yet.
  function automatic logic [15:0] pick_read_index();
    if (written_hi == 0 || $urandom_range(0, 99) < 20) return 16'($urandom_range(64000, 65535));
    return 16'($urandom_range(0, written_hi - 1));
  endfunction

  task automatic push_beat(input logic cmd, input logic [7:0] sb, input logic [15:0] ri);
    in_beat_t bt;
    bt.cmd   = cmd;
    bt.sbyte = sb;
    bt.ridx  = ri;
    beats_to_send.push_back(bt);
  endtask

  task automatic push_stream(input logic [7:0] b);
    push_beat(CMD_STREAM, b, 16'($urandom_range(0, 65535)));
  endtask

  task automatic push_read(input logic [15:0] ri);
    push_beat(CMD_READ, 8'($urandom_range(0, 255)), ri);
  endtask

  task automatic set_plane_length(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    px_plane_len = v;
  endtask

  task automatic wait_idle();
    while (beats_to_send.size() != 0 || in_valid || replies_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Builds well-formed runs with random content and interleaved reads. The pixel
  // budget keeps a batch from crossing more than one plane boundary.
  task automatic build_batch(input int n, input int budget, input bit long_runs);
    int     k;
    int     c;
    int     len;
    int     r;
    int     left;
    phase_t ph;
    ph   = px_phase;
    left = int'(px_lit_left);
    k    = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < 25) begin
        push_read(pick_read_index());
        k++;
      end else if (ph == PHASE_LITERAL) begin
        if (budget >= 8) begin
          push_stream(8'($urandom_range(0, 255)));
          budget -= 8;
          left--;
          if (left == 0) ph = PHASE_CMD;
        end else begin
          push_read(pick_read_index());
        end
        k++;
      end else if ($urandom_range(0, 99) < 55) begin
        if (long_runs && $urandom_range(0, 99) < 70) c = $urandom_range(96, 127);
        else c = $urandom_range(0, 127);
        if ((c + 3) * 8 > budget) c = budget / 8 - 3;
        if (c >= 0) begin
          push_stream(8'(c));
          if ($urandom_range(0, 4) == 0) begin
            push_read(pick_read_index());
            k++;
          end
          push_stream(8'($urandom_range(0, 255)));
          budget -= (c + 3) * 8;
          k += 2;
        end else begin
          push_read(pick_read_index());
          k++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 7);
        else if (r < 97) len = $urandom_range(8, 40);
        else len = 127;
        push_stream(8'(8'h80 | len));
        left = len + 1;
        ph   = PHASE_LITERAL;
        k++;
      end
    end
  endtask

  int in_gap = 0;

  always @(posedge clk) begin
    in_beat_t seen;
    in_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        seen.cmd   = in_cmd;
        seen.sbyte = in_stream_byte;
        seen.ridx  = in_read_index;
        decode_beat(seen);
      end
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (beats_to_send.size() > 0) begin
        nxt = beats_to_send.pop_front();
        in_cmd         <= nxt.cmd;
        in_stream_byte <= nxt.sbyte;
        in_read_index  <= nxt.ridx;
        in_valid       <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int out_stall = 0;

  always @(posedge clk) begin
    decoder_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 1);
        end else begin
          want = replies_due.pop_front();
          if (out_pixel_value !== want.pixel)
            report_mismatch("pixel_value", want.pixel, out_pixel_value);
          if (out_decode_done !== want.done)
            report_mismatch("decode_done", want.done, out_decode_done);
          if (out_current_plane !== want.plane)
            report_mismatch("current_plane", want.plane, out_current_plane);
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) out_stall = pick_gap();
      end
    end
  end

  initial begin
    int          sent;
    int          r;
    int          budget;
    logic [15:0] len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset plane length: reads past the store, the shortest literal command,
    // the shortest and longest repeat commands, and a read inside a literal run.
    push_read(16'd64000);
    push_read(16'hFFFF);
    push_stream(8'h80);
    push_stream(8'hFF);
    push_stream(8'h81);
    push_stream(8'h00);
    push_read(16'hFFFF);
    push_stream(8'hA5);
    push_stream(8'h00);
    push_stream(8'h5A);
    push_stream(8'h7F);
    push_read(16'd64000);
    push_stream(8'hC3);
    wait_idle();

    push_read(16'd0);
    push_read(16'd1);
    push_read(16'(written_hi - 1));
    push_read(16'(written_hi / 2));
    push_stream(8'h83);
    push_stream(8'h01);
    push_read(16'd0);
    push_stream(8'h80);
    push_stream(8'hFE);
    wait_idle();

    // The first plane runs past the end of the store before it wraps, so every
    // stored pixel is readable from then on.
    sent = 0;
    while (sent < 400) begin
      if (px_plane == 2'd0 || px_plane == 2'd3) begin
        len = 16'hFFFF;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) len = 16'($urandom_range(8, 300));
        else if (r < 70) len = 16'($urandom_range(300, 6000));
        else len = 16'($urandom_range(6000, 64000));
      end
      if (px_plane == 2'd3) budget = int'(len) - int'(px_count) - 1;
      else budget = int'(len);
      set_plane_length(len);
      build_batch($urandom_range(8, 24), budget, px_plane == 2'd0);
      sent += beats_to_send.size();
      wait_idle();
    end

    // A zero length ends a plane on every pixel, which finishes decoding.
    set_plane_length(16'd0);
    push_stream(8'h80);
    push_stream(8'($urandom_range(0, 255)));
    push_read(pick_read_index());
    push_stream(8'($urandom_range(0, 255)));
    push_stream(8'($urandom_range(0, 255)));
    push_read(pick_read_index());
    wait_idle();

    set_plane_length(16'd1);
    push_stream(8'($urandom_range(0, 255)));
    push_read(pick_read_index());
    push_stream(8'($urandom_range(0, 255)));
    push_read(pick_read_index());
    push_read(16'hFFFF);
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/prle_pkg.sv
rtl/prle_ctrl.sv
rtl/prle_datapath.sv
rtl/planar_rle_image_decoder_top.sv
dv/planar_rle_image_decoder_top_test.sv
